/* hdl/tls_pkg.sv */
`default_nettype none

package tls_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int ELAPSED_WIDTH   = 12;
    localparam int NUM_PHASES      = 6;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RED_BEFORE_NS = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NS_GREEN      = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NS_YELLOW     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RED_BEFORE_EW = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EW_GREEN      = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EW_YELLOW     = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE          = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CAMERA_LIMIT  = 3'd7;

    // phases
    localparam logic [2:0] PH_RED_NS     = 3'd0;
    localparam logic [2:0] PH_NS_GREEN   = 3'd1;
    localparam logic [2:0] PH_NS_YELLOW  = 3'd2;
    localparam logic [2:0] PH_RED_EW     = 3'd3;
    localparam logic [2:0] PH_EW_GREEN   = 3'd4;
    localparam logic [2:0] PH_EW_YELLOW  = 3'd5;

    // operating modes
    localparam logic [1:0] MODE_SIMPLE     = 2'd0;
    localparam logic [1:0] MODE_PEDESTRIAN = 2'd1;
    localparam logic [1:0] MODE_CONFIG     = 2'd2;
    localparam logic [1:0] MODE_CAMERA     = 2'd3;

    // vehicle status
    localparam logic [1:0] VEH_ABSENT  = 2'd0;
    localparam logic [1:0] VEH_ENTERED = 2'd1;
    localparam logic [1:0] VEH_CAMERA  = 2'd2;

    // lamp patterns
    localparam logic [7:0] LAMP_ALL_RED   = 8'h24;
    localparam logic [7:0] LAMP_NS_GREEN  = 8'h0C;
    localparam logic [7:0] LAMP_NS_YELLOW = 8'h14;
    localparam logic [7:0] LAMP_EW_GREEN  = 8'h21;
    localparam logic [7:0] LAMP_EW_YELLOW = 8'h22;
    localparam logic [7:0] LAMP_NS_WALK   = 8'h4C;
    localparam logic [7:0] LAMP_EW_WALK   = 8'hA1;

    // reset values
    localparam int RST_RED_TIME    = 500;
    localparam int RST_GREEN_TIME  = 6000;
    localparam int RST_YELLOW_TIME = 2000;
    localparam int RST_CAM_LIMIT   = 2000;

    typedef struct packed {
        logic vehicle_press;
        logic ped_ew_press;
        logic ped_ns_press;
        logic tick;
    } tls_item_t;

    typedef struct packed {
        logic       ns_walk_pending;
        logic       ew_walk_pending;
        logic [1:0] vehicle_status;
        logic       camera_running;
    } tls_flags_t;

    // packed with lamps in the lowest bits
    typedef struct packed {
        logic [ELAPSED_WIDTH-1:0] elapsed_ticks;
        logic                     time_report_valid;
        logic                     snapshot_taken;
        logic                     camera_started;
        logic [2:0]               phase_now;
        logic [7:0]               lamps;
    } tls_result_t;

endpackage

`default_nettype wire

/* hdl/tls_step.sv */
`default_nettype none

module tls_step #(
    parameter int TIMEOUT_WIDTH      = 14,
    parameter int CAMERA_COUNT_WIDTH = 12
) (
    input  tls_pkg::tls_item_t                                item,
    input  tls_pkg::tls_flags_t                               flags,
    input  logic [2:0]                                        phase,
    input  logic [TIMEOUT_WIDTH-1:0]                          countdown,
    input  logic [7:0]                                        lamps,
    input  logic [CAMERA_COUNT_WIDTH-1:0]                     cam_count,
    input  logic [1:0]                                        mode,
    input  logic [CAMERA_COUNT_WIDTH-1:0]                     cam_limit,
    input  logic [tls_pkg::NUM_PHASES-1:0][TIMEOUT_WIDTH-1:0] phase_time,
    output tls_pkg::tls_flags_t                               flags_next,
    output logic [2:0]                                        phase_next,
    output logic [TIMEOUT_WIDTH-1:0]                          countdown_next,
    output logic [7:0]                                        lamps_next,
    output logic [CAMERA_COUNT_WIDTH-1:0]                     cam_count_next,
    output tls_pkg::tls_result_t                              result
);
    import tls_pkg::*;

    logic [2:0]                    adv_phase;
    logic [CAMERA_COUNT_WIDTH-1:0] cam_inc;
    logic [31:0]                   cam_wide;
    logic                          walk_lamps;

    assign cam_inc    = cam_count + CAMERA_COUNT_WIDTH'(1);
    assign walk_lamps = (mode != MODE_SIMPLE);

    always_comb
    begin
        unique case (phase)
            PH_NS_GREEN:  adv_phase = PH_NS_YELLOW;
            PH_NS_YELLOW: adv_phase = PH_RED_EW;
            PH_RED_EW:    adv_phase = PH_EW_GREEN;
            PH_EW_GREEN:  adv_phase = PH_EW_YELLOW;
            PH_EW_YELLOW: adv_phase = PH_RED_NS;
            default:      adv_phase = PH_NS_GREEN;
        endcase
    end

    always_comb
    begin
        flags_next     = flags;
        phase_next     = phase;
        countdown_next = countdown;
        lamps_next     = lamps;
        cam_count_next = cam_count;
        cam_wide       = '0;
        result         = '0;

        if (item.ped_ns_press)
        begin
            flags_next.ns_walk_pending = 1'b1;
        end
        if (item.ped_ew_press)
        begin
            flags_next.ew_walk_pending = 1'b1;
        end
        if (item.vehicle_press)
        begin
            flags_next.vehicle_status = (flags.vehicle_status == VEH_ABSENT) ?
                                        VEH_ENTERED : VEH_ABSENT;
        end

        // camera counts before the phase timer runs
        if (item.tick && flags.camera_running)
        begin
            cam_count_next = cam_inc;
            if (cam_inc == cam_limit)
            begin
                result.snapshot_taken     = 1'b1;
                flags_next.camera_running = 1'b0;
            end
            else if (flags_next.vehicle_status != VEH_CAMERA)
            begin
                cam_wide                  = 32'(cam_inc);
                result.time_report_valid  = 1'b1;
                result.elapsed_ticks      = cam_wide[ELAPSED_WIDTH-1:0];
                flags_next.camera_running = 1'b0;
            end
        end

        if (item.tick)
        begin
            if (countdown <= TIMEOUT_WIDTH'(1))
            begin
                phase_next     = adv_phase;
                countdown_next = phase_time[adv_phase];
                case (adv_phase)
                    PH_NS_GREEN:
                    begin
                        if (walk_lamps && flags_next.ns_walk_pending)
                        begin
                            lamps_next                 = LAMP_NS_WALK;
                            flags_next.ns_walk_pending = 1'b0;
                        end
                        else
                        begin
                            lamps_next = LAMP_NS_GREEN;
                        end
                    end
                    PH_NS_YELLOW: lamps_next = LAMP_NS_YELLOW;
                    PH_EW_GREEN:
                    begin
                        if (walk_lamps && flags_next.ew_walk_pending)
                        begin
                            lamps_next                 = LAMP_EW_WALK;
                            flags_next.ew_walk_pending = 1'b0;
                        end
                        else
                        begin
                            lamps_next = LAMP_EW_GREEN;
                        end
                    end
                    PH_EW_YELLOW: lamps_next = LAMP_EW_YELLOW;
                    default:      lamps_next = LAMP_ALL_RED;
                endcase
            end
            else
            begin
                countdown_next = countdown - TIMEOUT_WIDTH'(1);
            end
        end

        if (mode == MODE_CAMERA && flags_next.vehicle_status == VEH_ENTERED &&
            (phase_next == PH_NS_YELLOW || phase_next == PH_EW_YELLOW))
        begin
            flags_next.vehicle_status = VEH_CAMERA;
            flags_next.camera_running = 1'b1;
            cam_count_next            = '0;
            result.camera_started     = 1'b1;
        end

        result.lamps     = lamps_next;
        result.phase_now = phase_next;
    end

endmodule

`default_nettype wire

/* hdl/traffic_light_sequencer.sv */
`default_nettype none

// Two-road traffic light sequencer. Each transfer on s_axis is one item (a
// millisecond tick and button edges); each yields one result on m_axis
// carrying the lamp pattern, the phase and the camera events. The state
// update for an item is a single combinational pass into the result
// register, and a new item is taken every cycle while the result register
// is empty or being drained and no cfg write is offered. Timeouts and the
// mode are written through the cfg channel (index 0..7); the user must write
// them only while no result is pending, which the block does not enforce. A
// mode write restarts the cycle at the all-red phase before north-south green.
module traffic_light_sequencer #(
    parameter int TIMEOUT_WIDTH      = 14,
    parameter int CAMERA_COUNT_WIDTH = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tick, ped_ns_press, ped_ew_press, vehicle_press, zero fill
    input  logic [7:0]                             s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // lamps[7:0], phase_now[10:8], camera_started, snapshot_taken,
    // time_report_valid, elapsed_ticks[25:14], zero fill
    output logic [31:0]                            m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tls_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tls_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
    import tls_pkg::*;

    logic [NUM_PHASES-1:0][TIMEOUT_WIDTH-1:0] phase_time_reg;
    logic [1:0]                               mode_reg;
    logic [CAMERA_COUNT_WIDTH-1:0]            cam_limit_reg;

    tls_flags_t                    flags_reg, flags_next;
    logic [2:0]                    phase_reg, phase_next;
    logic [TIMEOUT_WIDTH-1:0]      countdown_reg, countdown_next;
    logic [7:0]                    lamps_reg, lamps_next;
    logic [CAMERA_COUNT_WIDTH-1:0] cam_count_reg, cam_count_next;

    tls_result_t result_next, result_reg;
    logic        out_valid_reg;
    logic        in_xfer;
    logic        cfg_xfer;
    tls_item_t   item;

    assign item          = s_axis_tdata[3:0];
    // a cfg write holds off input so the two never share an edge
    assign s_axis_tready = (!out_valid_reg || m_axis_tready) && !cfg_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, result_reg};

    tls_step #(
        .TIMEOUT_WIDTH      (TIMEOUT_WIDTH),
        .CAMERA_COUNT_WIDTH (CAMERA_COUNT_WIDTH)
    ) u_step (
        .item           (item),
        .flags          (flags_reg),
        .phase          (phase_reg),
        .countdown      (countdown_reg),
        .lamps          (lamps_reg),
        .cam_count      (cam_count_reg),
        .mode           (mode_reg),
        .cam_limit      (cam_limit_reg),
        .phase_time     (phase_time_reg),
        .flags_next     (flags_next),
        .phase_next     (phase_next),
        .countdown_next (countdown_next),
        .lamps_next     (lamps_next),
        .cam_count_next (cam_count_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_time_reg[PH_RED_NS]    <= TIMEOUT_WIDTH'(RST_RED_TIME);
            phase_time_reg[PH_NS_GREEN]  <= TIMEOUT_WIDTH'(RST_GREEN_TIME);
            phase_time_reg[PH_NS_YELLOW] <= TIMEOUT_WIDTH'(RST_YELLOW_TIME);
            phase_time_reg[PH_RED_EW]    <= TIMEOUT_WIDTH'(RST_RED_TIME);
            phase_time_reg[PH_EW_GREEN]  <= TIMEOUT_WIDTH'(RST_GREEN_TIME);
            phase_time_reg[PH_EW_YELLOW] <= TIMEOUT_WIDTH'(RST_YELLOW_TIME);
            mode_reg      <= MODE_SIMPLE;
            cam_limit_reg <= CAMERA_COUNT_WIDTH'(RST_CAM_LIMIT);
            flags_reg     <= '0;
            phase_reg     <= PH_RED_NS;
            countdown_reg <= TIMEOUT_WIDTH'(RST_RED_TIME);
            lamps_reg     <= LAMP_ALL_RED;
            cam_count_reg <= '0;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                REG_RED_BEFORE_NS, REG_NS_GREEN, REG_NS_YELLOW,
                REG_RED_BEFORE_EW, REG_EW_GREEN, REG_EW_YELLOW:
                begin
                    phase_time_reg[cfg_index] <= cfg_data[TIMEOUT_WIDTH-1:0];
                end
                REG_MODE:
                begin
                    mode_reg      <= cfg_data[1:0];
                    phase_reg     <= PH_RED_NS;
                    countdown_reg <= phase_time_reg[PH_RED_NS];
                    lamps_reg     <= LAMP_ALL_RED;
                end
                REG_CAMERA_LIMIT:
                begin
                    cam_limit_reg <= cfg_data[CAMERA_COUNT_WIDTH-1:0];
                end
                default: ;
            endcase
        end
        else if (in_xfer)
        begin
            flags_reg     <= flags_next;
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            lamps_reg     <= lamps_next;
            cam_count_reg <= cam_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    // a snapshot stops the camera and leaves the vehicle under camera or gone, so the camera cannot restart
    a_snap_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !cfg_xfer && result_next.snapshot_taken) |=>
            !flags_reg.camera_running)
        else $error("camera still running after snapshot");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.snapshot_taken && result_reg.time_report_valid))
        else $error("snapshot and time report in one result");

    a_start_yellow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.camera_started) |->
            (result_reg.phase_now == PH_NS_YELLOW || result_reg.phase_now == PH_EW_YELLOW))
        else $error("camera started outside a yellow phase");

    a_lamp_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NS_YELLOW) |-> (lamps_reg == LAMP_NS_YELLOW))
        else $error("lamps do not match north-south yellow");

endmodule

`default_nettype wire

/* tb/tb_traffic_light_sequencer.sv */
`default_nettype none

module tb_traffic_light_sequencer;

    import tls_pkg::*;

    localparam int RESULT_BITS = $bits(tls_result_t);

    // single-field items (and the empty item) for the directed tests
    localparam tls_item_t IT_NONE = 4'b0000;
    localparam tls_item_t IT_TICK = 4'b0001;
    localparam tls_item_t IT_NS   = 4'b0010;
    localparam tls_item_t IT_EW   = 4'b0100;
    localparam tls_item_t IT_CAR  = 4'b1000;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [31:0]                m_axis_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // shadow of the sequencer: configuration
    logic [13:0] phase_len [NUM_PHASES] = '{14'(RST_RED_TIME), 14'(RST_GREEN_TIME),
                                           14'(RST_YELLOW_TIME), 14'(RST_RED_TIME),
                                           14'(RST_GREEN_TIME), 14'(RST_YELLOW_TIME)};
    logic [1:0]  op_mode   = MODE_SIMPLE;
    logic [11:0] cam_limit = 12'(RST_CAM_LIMIT);

    // shadow of the sequencer: state
    logic [2:0]  ph        = PH_RED_NS;
    logic [13:0] countdown = 14'(RST_RED_TIME);
    logic [7:0]  lamp      = LAMP_ALL_RED;
    logic        ns_req    = 1'b0;
    logic        ew_req    = 1'b0;
    logic [1:0]  veh       = VEH_ABSENT;
    logic [11:0] cam_cnt   = '0;
    logic        cam_on    = 1'b0;

    tls_result_t pending_results [$];
    int          mismatches = 0;
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;

    traffic_light_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // advances the shadow sequencer by one item and returns its result
    function automatic tls_result_t step_lights(tls_item_t it);
        tls_result_t r;
        logic [2:0]  nxt;
        r = '0;
        if (it.ped_ns_press)
            ns_req = 1'b1;
        if (it.ped_ew_press)
            ew_req = 1'b1;
        if (it.vehicle_press)
            veh = (veh == VEH_ABSENT) ? VEH_ENTERED : VEH_ABSENT;

        // camera counts before the phase timer; a camera started below skips this tick
        if (it.tick && cam_on)
        begin
            cam_cnt = cam_cnt + 12'd1;
            if (cam_cnt == cam_limit)
            begin
                r.snapshot_taken = 1'b1;
                cam_on = 1'b0;
            end
            else if (veh != VEH_CAMERA)
            begin
                r.time_report_valid = 1'b1;
                r.elapsed_ticks = cam_cnt;
                cam_on = 1'b0;
            end
        end

        if (it.tick)
        begin
            if (countdown <= 14'd1)
            begin
                if (ph == PH_EW_YELLOW)
                    nxt = PH_RED_NS;
                else if (ph == PH_RED_NS || ph > PH_EW_YELLOW)
                    nxt = PH_NS_GREEN;
                else
                    nxt = ph + 3'd1;
                case (nxt)
                    PH_NS_GREEN:
                    begin
                        if (op_mode != MODE_SIMPLE && ns_req)
                        begin
                            lamp = LAMP_NS_WALK;
                            ns_req = 1'b0;
                        end
                        else
                            lamp = LAMP_NS_GREEN;
                    end
                    PH_NS_YELLOW: lamp = LAMP_NS_YELLOW;
                    PH_EW_GREEN:
                    begin
                        if (op_mode != MODE_SIMPLE && ew_req)
                        begin
                            lamp = LAMP_EW_WALK;
                            ew_req = 1'b0;
                        end
                        else
                            lamp = LAMP_EW_GREEN;
                    end
                    PH_EW_YELLOW: lamp = LAMP_EW_YELLOW;
                    default:      lamp = LAMP_ALL_RED;
                endcase
                ph = nxt;
                countdown = phase_len[nxt];
            end
            else
                countdown = countdown - 14'd1;
        end

        if (op_mode == MODE_CAMERA && (ph == PH_NS_YELLOW || ph == PH_EW_YELLOW)
            && veh == VEH_ENTERED)
        begin
            veh = VEH_CAMERA;
            cam_cnt = '0;
            cam_on = 1'b1;
            r.camera_started = 1'b1;
        end

        r.lamps = lamp;
        r.phase_now = ph;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        tls_result_t got;
        tls_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[RESULT_BITS-1:0];
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: tdata 0x%0h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("lamps", 32'(want.lamps), 32'(got.lamps));
                check_field("phase_now", 32'(want.phase_now), 32'(got.phase_now));
                check_field("camera_started", 32'(want.camera_started),
                            32'(got.camera_started));
                check_field("snapshot_taken", 32'(want.snapshot_taken),
                            32'(got.snapshot_taken));
                check_field("time_report_valid", 32'(want.time_report_valid),
                            32'(got.time_report_valid));
                check_field("elapsed_ticks", 32'(want.elapsed_ticks),
                            32'(got.elapsed_ticks));
            end
        end
    end

    // receiver: stall rate changes between runs of random length, including no stalls at all
    initial
    begin
        int stall_pct;
        m_axis_tready = 1'b0;
        forever
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat ($urandom_range(20, 300))
            begin
                @(negedge clk);
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input tls_item_t it);
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, it};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(step_lights(it));
    endtask

    // sender goes quiet and every expected result is collected
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // registers are written only with nothing in flight
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_MODE)
        begin
            op_mode   = value[1:0];
            ph        = PH_RED_NS;
            countdown = phase_len[REG_RED_BEFORE_NS];
            lamp      = LAMP_ALL_RED;
        end
        else if (idx == REG_CAMERA_LIMIT)
            cam_limit = value[11:0];
        else
            phase_len[idx] = value[13:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all_timeouts(input logic [CFG_DATA_WIDTH-1:0] value);
        for (int idx = REG_RED_BEFORE_NS; idx <= REG_EW_YELLOW; idx++)
            write_reg(CFG_INDEX_WIDTH'(idx), value);
    endtask

    // reset lamps; requests latched in simple mode; vehicle toggles with no camera
    task automatic test_reset_state();
        send_item(IT_NONE);
        send_item(IT_TICK | IT_NS | IT_EW | IT_CAR);
        send_item(IT_CAR);
        wait_drained();
    endtask

    // whole cycle with short timeouts, zero acting as one, high data bits dropped
    task automatic test_phase_cycle();
        set_all_timeouts(1);
        write_reg(REG_RED_BEFORE_NS, 0);
        write_reg(REG_NS_GREEN, 2);
        write_reg(REG_NS_YELLOW, 32'hFFFF_C002);
        write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_SIMPLE));
        repeat (9) send_item(IT_TICK);
        wait_drained();
    endtask

    // walk lamps in pedestrian and configurable modes, requests consumed at green
    task automatic test_walk_lamps();
        set_all_timeouts(1);
        write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_PEDESTRIAN));
        repeat (6) send_item(IT_TICK);
        send_item(IT_TICK | IT_EW);
        write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_CONFIG));
        wait_drained();
        send_item(IT_NS);
        repeat (5) send_item(IT_TICK);
        wait_drained();
    endtask

    // camera start on yellow, early leave report, snapshot, no camera start after a change to pedestrian mode
    task automatic test_camera();
        set_all_timeouts(1);
        write_reg(REG_CAMERA_LIMIT, 3);
        write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_CAMERA));
        send_item(IT_CAR);
        repeat (3) send_item(IT_TICK);
        send_item(IT_TICK | IT_CAR);
        send_item(IT_CAR);
        repeat (5) send_item(IT_TICK);
        wait_drained();
        write_reg(REG_CAMERA_LIMIT, 5);
        write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_PEDESTRIAN));
        send_item(IT_CAR);
        send_item(IT_CAR);
        repeat (6) send_item(IT_TICK);
        wait_drained();
    endtask

    // yellow held long and the red before east-west at the longest timeout; with limit zero and limit at its maximum
    // the camera runs on until the vehicle leaves
    task automatic test_camera_extremes();
        gaps_on = 1'b0;
        set_all_timeouts(1);
        write_reg(REG_NS_YELLOW, 9999);
        write_reg(REG_RED_BEFORE_EW, 32'hFFFF_FFFF);
        write_reg(REG_EW_GREEN, 9999);
        write_reg(REG_EW_YELLOW, 9999);
        write_reg(REG_CAMERA_LIMIT, 0);
        write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_CAMERA));
        wait_drained();
        if (veh != VEH_ABSENT)
            send_item(IT_CAR);
        send_item(IT_CAR);
        repeat (2) send_item(IT_TICK);
        repeat (40) send_item(IT_TICK);
        send_item(IT_TICK | IT_CAR);
        wait_drained();
        write_reg(REG_CAMERA_LIMIT, 32'hFFFF_FFFF);
        send_item(IT_CAR);
        repeat (30) send_item(IT_TICK);
        send_item(IT_CAR);
        send_item(IT_TICK);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    function automatic logic [CFG_DATA_WIDTH-1:0] random_timeout();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(7, 30);
            2:       return 32'hFFFF_C000 | $urandom_range(1, 4);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    function automatic tls_item_t random_item();
        tls_item_t it;
        if ($urandom_range(0, 9) < 2)
            it = 4'($urandom_range(0, 15));
        else
        begin
            it.tick          = ($urandom_range(0, 99) < 80);
            it.ped_ns_press  = ($urandom_range(0, 99) < 8);
            it.ped_ew_press  = ($urandom_range(0, 99) < 8);
            it.vehicle_press = ($urandom_range(0, 99) < 8);
        end
        return it;
    endfunction

    // rounds of traffic, each under a fresh configuration; camera mode every other round
    task automatic test_random_traffic();
        logic [1:0] round_mode;
        for (int round = 0; round < 8; round++)
        begin
            wait_drained();
            for (int idx = REG_RED_BEFORE_NS; idx <= REG_EW_YELLOW; idx++)
                write_reg(CFG_INDEX_WIDTH'(idx), random_timeout());
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_CAMERA_LIMIT, $urandom_range(0, 4095));
            else
                write_reg(REG_CAMERA_LIMIT, $urandom_range(1, 12));
            case (round % 8)
                1, 7:    round_mode = MODE_SIMPLE;
                3:       round_mode = MODE_PEDESTRIAN;
                5:       round_mode = MODE_CONFIG;
                default: round_mode = MODE_CAMERA;
            endcase
            write_reg(REG_MODE, CFG_DATA_WIDTH'(round_mode));
            gaps_on = (round % 3 != 2);
            repeat (180) send_item(random_item());
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_phase_cycle();
        test_walk_lamps();
        test_camera();
        test_camera_extremes();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
hdl/tls_pkg.sv
hdl/tls_step.sv
hdl/traffic_light_sequencer.sv
tb/tb_traffic_light_sequencer.sv
